FILE: rtl/sha1md_pkg.sv
// Shared types, constants and codes for the streaming SHA-1 digest block.
// No dependencies; every other file in rtl imports it.
package sha1md_pkg;

	localparam int unsigned WORD_W   = 32;
	localparam int unsigned LEN_W    = 64;
	localparam int unsigned ROUNDS   = 80;
	localparam int unsigned RND_W    = 7;
	localparam int unsigned NWORDS   = 5;
	localparam int unsigned IDX_W    = 3;
	localparam int unsigned BPOS_W   = 6;

	localparam logic [WORD_W-1:0] K_0 = 32'h5A827999;
	localparam logic [WORD_W-1:0] K_1 = 32'h6ED9EBA1;
	localparam logic [WORD_W-1:0] K_2 = 32'h8F1BBCDC;
	localparam logic [WORD_W-1:0] K_3 = 32'hCA62C1D6;

	localparam logic [WORD_W-1:0] H_INIT [NWORDS] = '{
		32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
	};

	localparam logic [7:0]        PAD_BYTE  = 8'h80;
	localparam logic [BPOS_W-1:0] POS_FINAL = 6'd63;
	localparam logic [IDX_W-1:0]  IDX_FINAL = 3'd4;
	localparam logic [RND_W-1:0]  RND_FINAL = 7'd79;
	localparam logic [RND_W-1:0]  RND_MIX   = 7'd16;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_valid;
		logic       last;
	} msg_beat_t;

	typedef struct packed {
		logic [WORD_W-1:0] digest_word;
		logic [IDX_W-1:0]  word_index;
		logic              last_word;
	} dig_beat_t;

	typedef struct packed {
		logic [WORD_W-1:0] a;
		logic [WORD_W-1:0] b;
		logic [WORD_W-1:0] c;
		logic [WORD_W-1:0] d;
		logic [WORD_W-1:0] e;
	} vars_t;

	typedef struct packed {
		logic              clear;
		logic              wr_byte;
		logic [BPOS_W-1:0] byte_pos;
		logic [7:0]        byte_val;
		logic              wr_len;
		logic [LEN_W-1:0]  len;
		logic              shift;
		logic              use_mix;
	} sched_ctl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_ROUND,
		ST_ADD,
		ST_PAD,
		ST_LEN,
		ST_OUT
	} state_t;

	typedef enum logic [1:0] {
		RET_BYTE,
		RET_PAD,
		RET_LEN
	} ret_t;

endpackage

FILE: rtl/sha1_message_digest_top.sv
// Streaming SHA-1 digest: sequencer, hash state, bit count and digest output.
// Depends on sha1md_pkg, sha1md_sched, sha1md_round.
//
//   channel | handshake            | payload
//   msg     | msg_valid/msg_ready  | msg_beat (data_byte, byte_valid, last)
//   dig     | dig_valid/dig_ready  | dig_beat (digest_word, word_index, last_word)
//
// A byte that does not fill a block is only written into the buffer. A full block also needs
// one load, 80 rounds through the single round unit, one add back into the hash words.
// A last beat adds pad and length steps and one or two compressions, then five
// digest beats from an output register; msg_ready stays low until all five are loaded.
// Reset loads the initial hash words and clears the bit count; dig stalls hold the sequencer.
module sha1_message_digest_top
	import sha1md_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      msg_valid,
	output logic      msg_ready,
	input  msg_beat_t msg_beat,
	output logic      dig_valid,
	input  logic      dig_ready,
	output dig_beat_t dig_beat
);

	state_t            state_q, state_d;
	ret_t              ret_q, ret_d;
	logic              last_q;
	logic [RND_W-1:0]  rnd_q;
	logic [IDX_W-1:0]  oidx_q;
	logic [LEN_W-1:0]  bitlen_q;
	logic [WORD_W-1:0] hash_q [NWORDS];
	vars_t             vars_q, vars_nxt;
	logic              dvalid_q;
	dig_beat_t         dig_q;

	sched_ctl_t        ctl;
	logic [WORD_W-1:0] w_cur;
	logic              accept;
	logic [BPOS_W-1:0] pos;
	logic              bump_len, load_vars, step_vars, add_hash, load_out, done;

	sha1md_sched u_sched (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.w_cur  (w_cur)
	);

	sha1md_round u_round (
		.cur (vars_q),
		.w   (w_cur),
		.rnd (rnd_q),
		.nxt (vars_nxt)
	);

	assign pos       = bitlen_q[8:3];
	assign msg_ready = (state_q == ST_IDLE);
	assign accept    = msg_valid && msg_ready;
	assign dig_valid = dvalid_q;
	assign dig_beat  = dig_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		ret_d     = ret_q;
		ctl       = '0;
		ctl.len   = bitlen_q;
		bump_len  = 1'b0;
		load_vars = 1'b0;
		step_vars = 1'b0;
		add_hash  = 1'b0;
		load_out  = 1'b0;
		done      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (msg_beat.byte_valid) begin
						ctl.wr_byte  = 1'b1;
						ctl.byte_pos = pos;
						ctl.byte_val = msg_beat.data_byte;
						bump_len     = 1'b1;
					end
					if (msg_beat.byte_valid && pos == POS_FINAL) begin
						state_d = ST_START;
						ret_d   = RET_BYTE;
					end else if (msg_beat.last) begin
						state_d = ST_PAD;
					end
				end
			end
			ST_START: begin
				load_vars = 1'b1;
				state_d   = ST_ROUND;
			end
			ST_ROUND: begin
				ctl.shift   = 1'b1;
				ctl.use_mix = (rnd_q >= RND_MIX);
				step_vars   = 1'b1;
				if (rnd_q == RND_FINAL) state_d = ST_ADD;
			end
			ST_ADD: begin
				add_hash  = 1'b1;
				ctl.clear = 1'b1;
				case (ret_q)
					RET_BYTE: state_d = last_q ? ST_PAD : ST_IDLE;
					RET_PAD:  state_d = ST_LEN;
					RET_LEN:  state_d = ST_OUT;
					default:  state_d = ST_IDLE;
				endcase
			end
			ST_PAD: begin
				ctl.wr_byte  = 1'b1;
				ctl.byte_pos = pos;
				ctl.byte_val = PAD_BYTE;
				if (pos[5:3] == 3'b111) begin
					state_d = ST_START;
					ret_d   = RET_PAD;
				end else begin
					state_d = ST_LEN;
				end
			end
			ST_LEN: begin
				ctl.wr_len = 1'b1;
				state_d    = ST_START;
				ret_d      = RET_LEN;
			end
			ST_OUT: begin
				if (!dvalid_q || dig_ready) begin
					load_out = 1'b1;
					if (oidx_q == IDX_FINAL) begin
						done    = 1'b1;
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ret_q    <= RET_BYTE;
			last_q   <= 1'b0;
			rnd_q    <= '0;
			oidx_q   <= '0;
			bitlen_q <= '0;
			dvalid_q <= 1'b0;
			for (int i = 0; i < NWORDS; i++) hash_q[i] <= H_INIT[i];
		end else begin
			ret_q <= ret_d;
			if (accept) last_q <= msg_beat.last;
			if (bump_len) bitlen_q <= bitlen_q + LEN_W'(8);
			if (load_vars) rnd_q <= '0;
			else if (step_vars) rnd_q <= rnd_q + RND_W'(1);
			if (add_hash) begin
				hash_q[0] <= hash_q[0] + vars_q.a;
				hash_q[1] <= hash_q[1] + vars_q.b;
				hash_q[2] <= hash_q[2] + vars_q.c;
				hash_q[3] <= hash_q[3] + vars_q.d;
				hash_q[4] <= hash_q[4] + vars_q.e;
			end
			if (load_out) begin
				dvalid_q <= 1'b1;
				oidx_q   <= (oidx_q == IDX_FINAL) ? '0 : oidx_q + IDX_W'(1);
			end else if (dig_ready) begin
				dvalid_q <= 1'b0;
			end
			if (done) begin
				bitlen_q <= '0;
				for (int i = 0; i < NWORDS; i++) hash_q[i] <= H_INIT[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_vars) begin
			vars_q <= '{a: hash_q[0], b: hash_q[1], c: hash_q[2], d: hash_q[3], e: hash_q[4]};
		end else if (step_vars) begin
			vars_q <= vars_nxt;
		end
		if (load_out) begin
			dig_q.digest_word <= hash_q[oidx_q];
			dig_q.word_index  <= oidx_q;
			dig_q.last_word   <= (oidx_q == IDX_FINAL);
		end
	end

endmodule

FILE: rtl/sha1md_sched.sv
// Block buffer and message schedule: 16-word shift line with byte packing.
// Depends on sha1md_pkg.
module sha1md_sched
	import sha1md_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  sched_ctl_t        ctl,
	output logic [WORD_W-1:0] w_cur
);

	logic [WORD_W-1:0] w_q [16];
	logic [WORD_W-1:0] mix;
	logic [WORD_W-1:0] lane_word;
	logic [WORD_W-1:0] x;

	always_comb begin
		x     = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
		mix   = {x[WORD_W-2:0], x[WORD_W-1]};
		w_cur = ctl.use_mix ? mix : w_q[0];
		case (ctl.byte_pos[1:0])
			2'd0:    lane_word = {ctl.byte_val, 24'h0};
			2'd1:    lane_word = {8'h0, ctl.byte_val, 16'h0};
			2'd2:    lane_word = {16'h0, ctl.byte_val, 8'h0};
			default: lane_word = {24'h0, ctl.byte_val};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) w_q[i] <= '0;
		end else if (ctl.clear) begin
			for (int i = 0; i < 16; i++) w_q[i] <= '0;
		end else if (ctl.shift) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= w_cur;
		end else begin
			if (ctl.wr_byte)
				w_q[ctl.byte_pos[5:2]] <= w_q[ctl.byte_pos[5:2]] | lane_word;
			if (ctl.wr_len) begin
				w_q[14] <= ctl.len[LEN_W-1:WORD_W];
				w_q[15] <= ctl.len[WORD_W-1:0];
			end
		end
	end

endmodule

FILE: rtl/sha1md_round.sv
// One SHA-1 round: logic function, constant select and five-input add.
// Depends on sha1md_pkg.
module sha1md_round
	import sha1md_pkg::*;
(
	input  vars_t             cur,
	input  logic [WORD_W-1:0] w,
	input  logic [RND_W-1:0]  rnd,
	output vars_t             nxt
);

	logic [WORD_W-1:0] f;
	logic [WORD_W-1:0] k;

	always_comb begin
		if (rnd inside {[7'd0:7'd19]}) begin
			f = cur.d ^ (cur.b & (cur.c ^ cur.d));
			k = K_0;
		end else if (rnd inside {[7'd20:7'd39]}) begin
			f = cur.b ^ cur.c ^ cur.d;
			k = K_1;
		end else if (rnd inside {[7'd40:7'd59]}) begin
			f = (cur.b & cur.c) | (cur.d & (cur.b | cur.c));
			k = K_2;
		end else begin
			f = cur.b ^ cur.c ^ cur.d;
			k = K_3;
		end
		nxt.a = {cur.a[26:0], cur.a[31:27]} + f + cur.e + k + w;
		nxt.b = cur.a;
		nxt.c = {cur.b[1:0], cur.b[31:2]};
		nxt.d = cur.c;
		nxt.e = cur.d;
	end

endmodule

FILE: rtl/sha1md_chk.sv
// Port-level checks for the SHA-1 digest top level, bound onto every instance.
// Depends on sha1md_pkg and sha1_message_digest_top.
module sha1md_chk
	import sha1md_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      msg_valid,
	input logic      msg_ready,
	input msg_beat_t msg_beat,
	input logic      dig_valid,
	input logic      dig_ready,
	input dig_beat_t dig_beat
);

	a_last_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		msg_valid && msg_ready && msg_beat.last |=> !msg_ready)
		else $error("msg_ready high right after a last beat");

	a_last_idx: assert property (@(posedge clk) disable iff (!arst_n)
		dig_valid && dig_beat.last_word |-> dig_beat.word_index == IDX_FINAL)
		else $error("last_word on a beat other than the fifth");

	a_idx_step: assert property (@(posedge clk) disable iff (!arst_n)
		dig_valid && dig_ready && !dig_beat.last_word |=>
		dig_valid && dig_beat.word_index == $past(dig_beat.word_index) + IDX_W'(1))
		else $error("digest beats not back to back in order");

	a_first_idx: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(dig_valid) |-> dig_beat.word_index == '0)
		else $error("digest does not open with word zero");

	a_dig_hold: assert property (@(posedge clk) disable iff (!arst_n)
		dig_valid && !dig_ready |=> dig_valid && $stable(dig_beat))
		else $error("stalled digest beat changed");

endmodule

bind sha1_message_digest_top sha1md_chk u_chk (.*);
